[sv/arpc_pkg.sv]
// Shared types and codes for the ARP cache with pending requests.
`default_nettype none
package arpc_pkg;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_APPEND = 2'd1,
        K_INSERT = 2'd2,
        K_TICK   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_LOOKUP  = 3'd0,
        EV_SEND    = 3'd1,
        EV_QUEUED  = 3'd2,
        EV_FULL    = 3'd3,
        EV_RELEASE = 3'd4,
        EV_RESEND  = 3'd5,
        EV_UNREACH = 3'd6,
        EV_DONE    = 3'd7
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_AGE,
        S_E_EV,
        S_E_WR,
        S_P_RD,
        S_P_EV,
        S_P_WR,
        S_DONE
    } t_state;

    localparam logic CFG_MAX_AGE     = 1'b0;
    localparam logic CFG_RETRY_LIMIT = 1'b1;

    localparam logic [7:0] MAX_AGE_RST     = 8'd15;
    localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;
    localparam logic [4:0] RETRY_MAX       = 5'd31;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [3:0]  iface;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic        hit;
        logic [47:0] mac_out;
        logic [31:0] ip_out;
        logic [3:0]  iface_out;
        logic        last;
    } t_out;

    typedef struct packed {
        t_kind kind;
        logic  slot_valid;
        logic  ip_match;
        logic  iface_match;
        logic  over_limit;
        logic  have_free;
        logic  present;
        logic  last_idx;
        logic  out_free;
    } t_stat;

    typedef struct packed {
        logic   accept;
        logic   req_phase;
        logic   idx_clr;
        logic   idx_inc;
        logic   note_free;
        logic   note_present;
        logic   ent_write;
        logic   age_tick;
        logic   req_alloc;
        logic   req_clear;
        logic   req_retry_inc;
        logic   emit;
        t_event ev;
    } t_cmd;

endpackage
`default_nettype wire

[sv/arpc_ctrl.sv]
// Sequencer for lookup, append, insert and tick scans.
`default_nettype none
module arpc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire arpc_pkg::t_stat i_stat,
    output arpc_pkg::t_cmd      o_cmd,
    output logic                o_ready
);

    arpc_pkg::t_state r_state;
    arpc_pkg::t_state n_state;

    logic e_match;
    logic p_match;

    assign e_match = i_stat.slot_valid && i_stat.ip_match;
    assign p_match = i_stat.slot_valid && i_stat.ip_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            arpc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = arpc_pkg::S_START;
            end
            arpc_pkg::S_START: begin
                case (i_stat.kind)
                    arpc_pkg::K_LOOKUP, arpc_pkg::K_INSERT: n_state = arpc_pkg::S_E_EV;
                    arpc_pkg::K_APPEND: n_state = arpc_pkg::S_P_EV;
                    default: n_state = arpc_pkg::S_AGE;
                endcase
            end
            arpc_pkg::S_AGE: n_state = arpc_pkg::S_P_EV;
            arpc_pkg::S_E_EV: begin
                if (i_stat.kind == arpc_pkg::K_LOOKUP) begin
                    if (e_match || i_stat.last_idx) begin
                        if (i_stat.out_free) n_state = arpc_pkg::S_IDLE;
                    end else begin
                        n_state = arpc_pkg::S_START;
                    end
                end else begin
                    n_state = i_stat.last_idx ? arpc_pkg::S_E_WR : arpc_pkg::S_START;
                end
            end
            arpc_pkg::S_E_WR: n_state = arpc_pkg::S_P_RD;
            arpc_pkg::S_P_RD: n_state = arpc_pkg::S_P_EV;
            arpc_pkg::S_P_EV: begin
                case (i_stat.kind)
                    arpc_pkg::K_APPEND: begin
                        if (p_match && i_stat.iface_match) begin
                            if (i_stat.out_free) n_state = arpc_pkg::S_IDLE;
                        end else if (i_stat.last_idx) begin
                            if (i_stat.have_free || !i_stat.slot_valid) begin
                                n_state = arpc_pkg::S_P_WR;
                            end else if (i_stat.out_free) begin
                                n_state = arpc_pkg::S_IDLE;
                            end
                        end else begin
                            n_state = arpc_pkg::S_P_RD;
                        end
                    end
                    arpc_pkg::K_INSERT: begin
                        if (!p_match || i_stat.out_free) begin
                            n_state = i_stat.last_idx ? arpc_pkg::S_DONE : arpc_pkg::S_P_RD;
                        end
                    end
                    default: begin
                        if (!i_stat.slot_valid || i_stat.out_free) begin
                            n_state = i_stat.last_idx ? arpc_pkg::S_DONE : arpc_pkg::S_P_RD;
                        end
                    end
                endcase
            end
            arpc_pkg::S_P_WR, arpc_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = arpc_pkg::S_IDLE;
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.ev = arpc_pkg::EV_DONE;
        o_ready = 1'b0;
        case (r_state)
            arpc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            arpc_pkg::S_START: begin
                o_cmd.req_phase = (i_stat.kind == arpc_pkg::K_APPEND);
            end
            arpc_pkg::S_AGE: begin
                o_cmd.age_tick = 1'b1;
                o_cmd.req_phase = 1'b1;
            end
            arpc_pkg::S_E_EV: begin
                if (i_stat.kind == arpc_pkg::K_LOOKUP) begin
                    if (e_match || i_stat.last_idx) begin
                        o_cmd.emit = i_stat.out_free;
                        o_cmd.ev = arpc_pkg::EV_LOOKUP;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    o_cmd.note_free = 1'b1;
                    o_cmd.note_present = 1'b1;
                    o_cmd.idx_inc = !i_stat.last_idx;
                end
            end
            arpc_pkg::S_E_WR: begin
                o_cmd.ent_write = !i_stat.present;
                o_cmd.idx_clr = 1'b1;
            end
            arpc_pkg::S_P_RD: begin
                o_cmd.req_phase = 1'b1;
            end
            arpc_pkg::S_P_EV: begin
                o_cmd.req_phase = 1'b1;
                case (i_stat.kind)
                    arpc_pkg::K_APPEND: begin
                        if (p_match && i_stat.iface_match) begin
                            o_cmd.emit = i_stat.out_free;
                            o_cmd.ev = arpc_pkg::EV_QUEUED;
                        end else begin
                            o_cmd.note_free = 1'b1;
                            if (i_stat.last_idx) begin
                                if (i_stat.slot_valid && !i_stat.have_free) begin
                                    o_cmd.emit = i_stat.out_free;
                                    o_cmd.ev = arpc_pkg::EV_FULL;
                                end
                            end else begin
                                o_cmd.idx_inc = 1'b1;
                            end
                        end
                    end
                    arpc_pkg::K_INSERT: begin
                        if (p_match) begin
                            o_cmd.emit = i_stat.out_free;
                            o_cmd.req_clear = i_stat.out_free;
                            o_cmd.ev = arpc_pkg::EV_RELEASE;
                        end
                        o_cmd.idx_inc = (!p_match || i_stat.out_free) && !i_stat.last_idx;
                    end
                    default: begin
                        if (i_stat.slot_valid) begin
                            o_cmd.emit = i_stat.out_free;
                            o_cmd.req_clear = i_stat.out_free && i_stat.over_limit;
                            o_cmd.req_retry_inc = i_stat.out_free && !i_stat.over_limit;
                            o_cmd.ev = i_stat.over_limit ? arpc_pkg::EV_UNREACH
                                                         : arpc_pkg::EV_RESEND;
                        end
                        o_cmd.idx_inc = (!i_stat.slot_valid || i_stat.out_free)
                                        && !i_stat.last_idx;
                    end
                endcase
            end
            arpc_pkg::S_P_WR: begin
                o_cmd.req_phase = 1'b1;
                o_cmd.req_alloc = i_stat.out_free;
                o_cmd.emit = i_stat.out_free;
                o_cmd.ev = arpc_pkg::EV_SEND;
            end
            arpc_pkg::S_DONE: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.ev = arpc_pkg::EV_DONE;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[sv/arpc_dp.sv]
// Mapping and request tables, scan registers and result register.
`default_nettype none
module arpc_dp #(
    parameter int TABLE_DEPTH   = 32,
    parameter int PENDING_DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire arpc_pkg::t_in   i_in_data,
    input  wire arpc_pkg::t_cmd  i_cmd,
    output arpc_pkg::t_stat      o_stat,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output arpc_pkg::t_out       o_out_data,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [7:0]      i_cfg_data
);

    localparam int EW = $clog2(TABLE_DEPTH);
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int IW = (EW > PW) ? EW : PW;

    logic [7:0]          r_max_age;
    logic [3:0]          r_retry_limit;
    arpc_pkg::t_in       r_in;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_free;
    logic                r_have_free;
    logic                r_present;
    logic [EW-1:0]       r_victim;

    logic [TABLE_DEPTH-1:0] r_ent_vld;
    logic [7:0]          r_ent_age [TABLE_DEPTH];
    logic [31:0]         r_mem_eip [TABLE_DEPTH];
    logic [47:0]         r_mem_emac [TABLE_DEPTH];
    logic [31:0]         r_rd_eip;
    logic [47:0]         r_rd_emac;

    logic [PENDING_DEPTH-1:0] r_req_vld;
    logic [31:0]         r_mem_rip [PENDING_DEPTH];
    logic [3:0]          r_mem_rif [PENDING_DEPTH];
    logic [4:0]          r_mem_rret [PENDING_DEPTH];
    logic [31:0]         r_rd_rip;
    logic [3:0]          r_rd_rif;
    logic [4:0]          r_rd_rret;

    logic                r_out_vld;
    arpc_pkg::t_out      r_out;
    arpc_pkg::t_out      n_out;

    logic [EW-1:0]       e_idx;
    logic [PW-1:0]       p_idx;
    logic [EW-1:0]       ent_slot;
    logic [PW-1:0]       req_slot;
    logic                slot_valid;
    logic                ip_match;
    logic                out_free;
    logic [4:0]          ret_inc;

    assign e_idx    = r_idx[EW-1:0];
    assign p_idx    = r_idx[PW-1:0];
    assign ent_slot = r_have_free ? r_free[EW-1:0] : r_victim;
    assign req_slot = r_free[PW-1:0];
    assign slot_valid = i_cmd.req_phase ? r_req_vld[p_idx] : r_ent_vld[e_idx];
    assign ip_match   = i_cmd.req_phase ? (r_rd_rip == r_in.ip_addr)
                                        : (r_rd_eip == r_in.ip_addr);
    assign out_free = !r_out_vld || !i_out_stall;
    assign ret_inc  = (r_rd_rret == arpc_pkg::RETRY_MAX) ? r_rd_rret : r_rd_rret + 5'd1;

    always_comb begin
        o_stat.kind        = arpc_pkg::t_kind'(r_in.kind);
        o_stat.slot_valid  = slot_valid;
        o_stat.ip_match    = ip_match;
        o_stat.iface_match = (r_rd_rif == r_in.iface);
        o_stat.over_limit  = (r_rd_rret > {1'b0, r_retry_limit});
        o_stat.have_free   = r_have_free;
        o_stat.present     = r_present;
        o_stat.last_idx    = i_cmd.req_phase ? (r_idx == IW'(PENDING_DEPTH - 1))
                                             : (r_idx == IW'(TABLE_DEPTH - 1));
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age     <= arpc_pkg::MAX_AGE_RST;
            r_retry_limit <= arpc_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == arpc_pkg::CFG_MAX_AGE) r_max_age <= i_cfg_data;
            if (i_cfg_idx == arpc_pkg::CFG_RETRY_LIMIT) r_retry_limit <= i_cfg_data[3:0];
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_have_free <= 1'b0;
            r_present   <= 1'b0;
            r_victim    <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_idx       <= '0;
                r_have_free <= 1'b0;
                r_present   <= 1'b0;
            end else if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.note_free && !r_have_free && !slot_valid) begin
                r_have_free <= 1'b1;
            end
            if (i_cmd.note_present && slot_valid && ip_match) begin
                r_present <= 1'b1;
            end
            if (i_cmd.ent_write && !r_have_free) begin
                r_victim <= (r_victim == EW'(TABLE_DEPTH - 1)) ? '0 : r_victim + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_in <= i_in_data;
        if (i_cmd.note_free && !r_have_free && !slot_valid) r_free <= r_idx;
    end

    // mapping table: valid and age in flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++) r_ent_age[i] <= '0;
        end else if (i_cmd.age_tick) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (r_ent_vld[i]) begin
                    if (r_ent_age[i] >= r_max_age) r_ent_vld[i] <= 1'b0;
                    else r_ent_age[i] <= r_ent_age[i] + 8'd1;
                end
            end
        end else if (i_cmd.ent_write) begin
            r_ent_vld[ent_slot] <= 1'b1;
            r_ent_age[ent_slot] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_write) begin
            r_mem_eip[ent_slot]  <= r_in.ip_addr;
            r_mem_emac[ent_slot] <= r_in.mac_addr;
        end
        r_rd_eip  <= r_mem_eip[e_idx];
        r_rd_emac <= r_mem_emac[e_idx];
    end

    // request table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= '0;
        end else if (i_cmd.req_alloc) begin
            r_req_vld[req_slot] <= 1'b1;
        end else if (i_cmd.req_clear) begin
            r_req_vld[p_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_alloc) begin
            r_mem_rip[req_slot]  <= r_in.ip_addr;
            r_mem_rif[req_slot]  <= r_in.iface;
            r_mem_rret[req_slot] <= '0;
        end else if (i_cmd.req_retry_inc) begin
            r_mem_rret[p_idx] <= ret_inc;
        end
        r_rd_rip  <= r_mem_rip[p_idx];
        r_rd_rif  <= r_mem_rif[p_idx];
        r_rd_rret <= r_mem_rret[p_idx];
    end

    // result formatting
    always_comb begin
        n_out = '0;
        n_out.event_res = i_cmd.ev;
        n_out.last = 1'b1;
        case (i_cmd.ev)
            arpc_pkg::EV_LOOKUP: begin
                n_out.hit     = slot_valid && ip_match;
                n_out.mac_out = (slot_valid && ip_match) ? r_rd_emac : '0;
                n_out.ip_out  = r_in.ip_addr;
            end
            arpc_pkg::EV_SEND, arpc_pkg::EV_QUEUED, arpc_pkg::EV_FULL: begin
                n_out.ip_out    = r_in.ip_addr;
                n_out.iface_out = r_in.iface;
            end
            arpc_pkg::EV_RELEASE: begin
                n_out.mac_out   = r_in.mac_addr;
                n_out.ip_out    = r_in.ip_addr;
                n_out.iface_out = r_rd_rif;
                n_out.last      = 1'b0;
            end
            arpc_pkg::EV_RESEND, arpc_pkg::EV_UNREACH: begin
                n_out.ip_out    = r_rd_rip;
                n_out.iface_out = r_rd_rif;
                n_out.last      = 1'b0;
            end
            default: begin
                n_out.ip_out = (r_in.kind == arpc_pkg::K_INSERT) ? r_in.ip_addr : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_vld || !i_out_stall))
        else $error("result written over a pending transfer");
    a_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_idx == '0 && !r_have_free && !r_present))
        else $error("scan state not cleared on accept");
    a_alloc_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.req_alloc |=> (r_req_vld != '0))
        else $error("request allocated but no slot valid");
`endif

endmodule
`default_nettype wire

[sv/arp_cache_with_pending_requests.sv]
// Top level of the ARP cache with pending requests.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+-------------------------
//  input     | in  | i_in_valid / o_in_stall    | i_in_data  (t_in)
//  result    | out | o_out_valid / i_out_stall  | o_out_data (t_out)
//  config    | in  | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item at a time. The tables are scanned one slot at a time through
// registered memory reads: a slot is read, then its event state acts on it.
// A lookup walks the mapping table, an append the request table, an insert
// the mapping table and then the request table, and a tick ages all entries
// in a single state and then walks only the request table.
// Reset is synchronous; valid bits and ages clear at once, no clearing pass.
// A stalled result holds the scan in place wherever a result is to be written;
// the next transfer is written in the cycle the previous one leaves.
`default_nettype none
module arp_cache_with_pending_requests #(
    parameter int TABLE_DEPTH   = 32,
    parameter int PENDING_DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire arpc_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output arpc_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [7:0]     i_cfg_data
);

    arpc_pkg::t_cmd  cmd;
    arpc_pkg::t_stat stat;
    logic            ready;

    // stall inputs whenever a scan is in progress
    assign o_in_stall = !ready;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    arpc_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the ARP cache with pending requests.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    localparam int TDEPTH = 32;
    localparam int PDEPTH = 16;
    localparam int CYCLE_LIMIT = 900000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    arpc_pkg::t_in   i_in_data;
    logic            o_out_valid;
    logic            i_out_stall;
    arpc_pkg::t_out  o_out_data;
    logic            i_cfg_we;
    logic            i_cfg_idx;
    logic [7:0]      i_cfg_data;

    arp_cache_with_pending_requests uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Shadow copy of the cache state used to predict each result.
    logic        cache_vld [TDEPTH];
    logic [31:0] cache_ip  [TDEPTH];
    logic [47:0] cache_mac [TDEPTH];
    logic [7:0]  cache_age [TDEPTH];
    logic [4:0]  victim;
    logic        req_vld   [PDEPTH];
    logic [31:0] req_ip    [PDEPTH];
    logic [3:0]  req_if    [PDEPTH];
    logic [4:0]  req_retry [PDEPTH];
    logic [7:0]  age_limit;
    logic [3:0]  retry_cap;

    arpc_pkg::t_in  send_queue [$];
    arpc_pkg::t_out expected_events [$];
    int   errors;
    int   cycles;
    int   send_idle_pct;
    int   stall_pct;

    function automatic arpc_pkg::t_out make_event(arpc_pkg::t_event ev, logic hit,
                                                  logic [47:0] mac, logic [31:0] ip,
                                                  logic [3:0] ifc, logic lst);
        arpc_pkg::t_out r;
        r.event_res = ev;
        r.hit = hit;
        r.mac_out = mac;
        r.ip_out = ip;
        r.iface_out = ifc;
        r.last = lst;
        return r;
    endfunction

    // Advance the shadow state by one item and queue its events.
    task automatic predict_events(input arpc_pkg::t_in item);
        int  free_idx;
        bit  found;
        int  slot;
        begin
            free_idx = -1;
            found = 0;
            case (arpc_pkg::t_kind'(item.kind))
                arpc_pkg::K_LOOKUP: begin
                    for (int i = 0; i < TDEPTH; i++)
                        if (!found && cache_vld[i] && cache_ip[i] == item.ip_addr) begin
                            found = 1;
                            expected_events.push_back(make_event(arpc_pkg::EV_LOOKUP, 1'b1,
                                cache_mac[i], item.ip_addr, 4'd0, 1'b1));
                        end
                    if (!found)
                        expected_events.push_back(make_event(arpc_pkg::EV_LOOKUP, 1'b0,
                            48'd0, item.ip_addr, 4'd0, 1'b1));
                end
                arpc_pkg::K_APPEND: begin
                    for (int i = 0; i < PDEPTH; i++) begin
                        if (req_vld[i]) begin
                            if (req_ip[i] == item.ip_addr && req_if[i] == item.iface)
                                found = 1;
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (found)
                        expected_events.push_back(make_event(arpc_pkg::EV_QUEUED, 1'b0,
                            48'd0, item.ip_addr, item.iface, 1'b1));
                    else if (free_idx < 0)
                        expected_events.push_back(make_event(arpc_pkg::EV_FULL, 1'b0,
                            48'd0, item.ip_addr, item.iface, 1'b1));
                    else begin
                        req_vld[free_idx] = 1'b1;
                        req_ip[free_idx] = item.ip_addr;
                        req_if[free_idx] = item.iface;
                        req_retry[free_idx] = 5'd0;
                        expected_events.push_back(make_event(arpc_pkg::EV_SEND, 1'b0,
                            48'd0, item.ip_addr, item.iface, 1'b1));
                    end
                end
                arpc_pkg::K_INSERT: begin
                    for (int i = 0; i < TDEPTH; i++) begin
                        if (cache_vld[i]) begin
                            if (cache_ip[i] == item.ip_addr) found = 1;
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (!found) begin
                        if (free_idx >= 0) slot = free_idx;
                        else begin
                            slot = victim;
                            victim = victim + 5'd1;
                        end
                        cache_vld[slot] = 1'b1;
                        cache_ip[slot] = item.ip_addr;
                        cache_mac[slot] = item.mac_addr;
                        cache_age[slot] = 8'd0;
                    end
                    for (int i = 0; i < PDEPTH; i++)
                        if (req_vld[i] && req_ip[i] == item.ip_addr) begin
                            expected_events.push_back(make_event(arpc_pkg::EV_RELEASE, 1'b0,
                                item.mac_addr, item.ip_addr, req_if[i], 1'b0));
                            req_vld[i] = 1'b0;
                        end
                    expected_events.push_back(make_event(arpc_pkg::EV_DONE, 1'b0, 48'd0,
                        item.ip_addr, 4'd0, 1'b1));
                end
                default: begin
                    for (int i = 0; i < TDEPTH; i++)
                        if (cache_vld[i]) begin
                            if (cache_age[i] >= age_limit) cache_vld[i] = 1'b0;
                            else cache_age[i] = cache_age[i] + 8'd1;
                        end
                    for (int i = 0; i < PDEPTH; i++) begin
                        if (req_vld[i]) begin
                            if (req_retry[i] > {1'b0, retry_cap}) begin
                                expected_events.push_back(make_event(arpc_pkg::EV_UNREACH,
                                    1'b0, 48'd0, req_ip[i], req_if[i], 1'b0));
                                req_vld[i] = 1'b0;
                            end else begin
                                expected_events.push_back(make_event(arpc_pkg::EV_RESEND,
                                    1'b0, 48'd0, req_ip[i], req_if[i], 1'b0));
                                if (req_retry[i] < arpc_pkg::RETRY_MAX) req_retry[i]++;
                            end
                        end
                    end
                    expected_events.push_back(make_event(arpc_pkg::EV_DONE, 1'b0, 48'd0,
                        32'd0, 4'd0, 1'b1));
                end
            endcase
        end
    endtask

    // Stall as seen at the last rising edge, so the driver knows a transfer happened.
    logic o_in_stall_q;
    always @(posedge i_clk) o_in_stall_q <= o_in_stall;

    // Driver: present queued items at the falling edge, hold while stalled.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_q) begin
                if (send_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_in_data <= send_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (send_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_in_data <= send_queue.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Monitor: predict on each input transfer, check each result transfer.
    always @(posedge i_clk) begin
        arpc_pkg::t_out want;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (i_in_valid && !o_in_stall)
                predict_events(i_in_data);
            if (o_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (want.event_res !== o_out_data.event_res)
                        $display("%0t: event_res expected %0d actual %0d", $time,
                            want.event_res, o_out_data.event_res);
                    if (want.hit !== o_out_data.hit)
                        $display("%0t: hit expected %0d actual %0d", $time,
                            want.hit, o_out_data.hit);
                    if (want.mac_out !== o_out_data.mac_out)
                        $display("%0t: mac_out expected %h actual %h", $time,
                            want.mac_out, o_out_data.mac_out);
                    if (want.ip_out !== o_out_data.ip_out)
                        $display("%0t: ip_out expected %h actual %h", $time,
                            want.ip_out, o_out_data.ip_out);
                    if (want.iface_out !== o_out_data.iface_out)
                        $display("%0t: iface_out expected %0d actual %0d", $time,
                            want.iface_out, o_out_data.iface_out);
                    if (want.last !== o_out_data.last)
                        $display("%0t: last expected %0d actual %0d", $time,
                            want.last, o_out_data.last);
                    if (want !== o_out_data) errors++;
                end
            end
            if (cycles >= CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic arpc_pkg::t_in make_item(arpc_pkg::t_kind k, logic [31:0] ip,
                                                logic [47:0] mac, logic [3:0] ifc);
        arpc_pkg::t_in r;
        r.kind = k;
        r.ip_addr = ip;
        r.mac_addr = mac;
        r.iface = ifc;
        return r;
    endfunction

    // Draw addresses mostly from a small pool so hits, queueing and releases occur.
    function automatic logic [31:0] pick_ip();
        if ($urandom_range(9, 0) < 8) return 32'h0A00_0000 + $urandom_range(40, 0);
        return $urandom();
    endfunction

    function automatic arpc_pkg::t_in random_item();
        int roll;
        logic [47:0] mac;
        roll = $urandom_range(99, 0);
        mac = 48'({$urandom(), $urandom()});
        if (roll < 30)
            return make_item(arpc_pkg::K_LOOKUP, pick_ip(), mac, 4'($urandom()));
        if (roll < 60)
            return make_item(arpc_pkg::K_APPEND, pick_ip(), mac,
                             4'($urandom_range(3, 0) * 5));
        if (roll < 88)
            return make_item(arpc_pkg::K_INSERT, pick_ip(), mac, 4'($urandom()));
        return make_item(arpc_pkg::K_TICK, $urandom(), mac, 4'($urandom()));
    endfunction

    task automatic wait_drained();
        begin
            while (send_queue.size() > 0 || i_in_valid || expected_events.size() > 0)
                @(posedge i_clk);
            repeat (2 * (TDEPTH + PDEPTH) + 20) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_data <= value;
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            if (idx == arpc_pkg::CFG_MAX_AGE) age_limit = value;
            else retry_cap = value[3:0];
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = arpc_pkg::CFG_MAX_AGE;
        i_cfg_data = 8'd0;
        for (int i = 0; i < TDEPTH; i++) begin
            cache_vld[i] = 1'b0; cache_ip[i] = '0; cache_mac[i] = '0; cache_age[i] = '0;
        end
        for (int i = 0; i < PDEPTH; i++) begin
            req_vld[i] = 1'b0; req_ip[i] = '0; req_if[i] = '0; req_retry[i] = '0;
        end
        victim = '0;
        age_limit = arpc_pkg::MAX_AGE_RST;
        retry_cap = arpc_pkg::RETRY_LIMIT_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every kind, pending table full, release, aging.
        send_queue.push_back(make_item(arpc_pkg::K_LOOKUP, 32'hFFFF_FFFF,
                                       48'hFFFF_FFFF_FFFF, 4'hF));
        send_queue.push_back(make_item(arpc_pkg::K_INSERT, 32'hFFFF_FFFF,
                                       48'hFFFF_FFFF_FFFF, 4'hF));
        send_queue.push_back(make_item(arpc_pkg::K_INSERT, 32'h0, 48'h0, 4'h0));
        send_queue.push_back(make_item(arpc_pkg::K_INSERT, 32'hFFFF_FFFF, 48'h1234, 4'h0));
        send_queue.push_back(make_item(arpc_pkg::K_LOOKUP, 32'hFFFF_FFFF, 48'h0, 4'h0));
        send_queue.push_back(make_item(arpc_pkg::K_LOOKUP, 32'h0, 48'h0, 4'h0));
        for (int i = 0; i < 17; i++)
            send_queue.push_back(make_item(arpc_pkg::K_APPEND, 32'hC0A8_0000 + i,
                                           48'h0, i[3:0]));
        send_queue.push_back(make_item(arpc_pkg::K_APPEND, 32'hC0A8_0001, 48'h0, 4'h1));
        send_queue.push_back(make_item(arpc_pkg::K_INSERT, 32'hC0A8_0003,
                                       48'hA5A5_5A5A_0F0F, 4'h0));
        send_queue.push_back(make_item(arpc_pkg::K_TICK, 32'h0, 48'h0, 4'h0));
        wait_drained();

        // Random phases across settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(arpc_pkg::CFG_MAX_AGE, 8'd0);
                    write_reg(arpc_pkg::CFG_RETRY_LIMIT, 8'd0);
                end
                2: begin
                    write_reg(arpc_pkg::CFG_MAX_AGE, 8'd255);
                    write_reg(arpc_pkg::CFG_RETRY_LIMIT, 8'd15);
                end
                4: begin
                    write_reg(arpc_pkg::CFG_MAX_AGE, 8'd3);
                    write_reg(arpc_pkg::CFG_RETRY_LIMIT, 8'd2);
                end
                6: begin
                    write_reg(arpc_pkg::CFG_MAX_AGE, 8'($urandom()));
                    write_reg(arpc_pkg::CFG_RETRY_LIMIT, 8'($urandom()));
                end
                default: ;
            endcase
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 34 : 61) : 0;
            stall_pct = (ph % 4 == 2) ? 61 : (ph % 4 == 3 ? 34 : 0);
            for (int n = 0; n < 56; n++)
                send_queue.push_back(random_item());
            wait_drained();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
